/* sv/upd_pkg.sv */
// upd_pkg: shared types, character constants and hex helpers for the
// url percent decoder; no dependencies
`default_nettype none

package upd_pkg;

  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  // offsets that map a hex digit character to its value
  localparam logic [7:0] OFS_DIGIT  = 8'h30;  // '0'
  localparam logic [7:0] OFS_LOWER  = 8'h57;  // 'a' - 10
  localparam logic [7:0] OFS_UPPER  = 8'h37;  // 'A' - 10

  // emit request from the classifier to the emitter: cnt bytes, 1 to 3
  typedef struct packed {
    logic [1:0] cnt;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic       last;
  } cmd_t;

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
           (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] d;
    if (c >= 8'h30 && c <= 8'h39) d = c - OFS_DIGIT;
    else if (c >= 8'h61 && c <= 8'h66) d = c - OFS_LOWER;
    else d = c - OFS_UPPER;
    return d[3:0];
  endfunction

  function automatic logic [7:0] plain_map(input logic [7:0] c);
    return (c == CH_PLUS) ? CH_SPACE : c;
  endfunction

endpackage

`default_nettype wire

/* sv/upd_front.sv */
// upd_front: escape tracking and classification of each input byte into an
// emit request of one to three bytes, or into none; depends on upd_pkg
`default_nettype none

module upd_front (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         acc,
  input  wire logic [7:0]   in_byte,
  input  wire logic         in_last,
  output upd_pkg::cmd_t     cmd,
  output logic              cmd_push
);
  import upd_pkg::*;

  localparam logic [1:0] PH_PLAIN = 2'd0;
  localparam logic [1:0] PH_PCT   = 2'd1;
  localparam logic [1:0] PH_HELD  = 2'd2;

  logic [1:0] phase_r, phase_nxt;
  logic [7:0] held_r, held_nxt;
  logic       emit;

  // classify the byte against the escape phase
  always_comb begin
    phase_nxt = PH_PLAIN;
    held_nxt  = held_r;
    emit      = 1'b1;
    cmd       = '{cnt: 2'd1, b0: plain_map(in_byte), b1: 8'h00, b2: 8'h00,
                  last: in_last};
    unique case (phase_r)
      PH_PCT: begin
        held_nxt = in_byte;
        if (in_last) begin
          cmd = '{cnt: 2'd2, b0: CH_PERCENT, b1: plain_map(in_byte), b2: 8'h00,
                  last: 1'b1};
        end else begin
          phase_nxt = PH_HELD;
          emit      = 1'b0;
        end
      end
      PH_HELD: begin
        if (is_hex(held_r) && is_hex(in_byte)) begin
          cmd.b0 = {hex_val(held_r), hex_val(in_byte)};
        end else begin
          cmd = '{cnt: 2'd3, b0: CH_PERCENT, b1: held_r, b2: in_byte,
                  last: in_last};
        end
      end
      default: begin
        // plain text, unused phase code behaves the same
        if (in_byte == CH_PERCENT && !in_last) begin
          phase_nxt = PH_PCT;
          emit      = 1'b0;
        end
      end
    endcase
  end

  assign cmd_push = acc && emit;

  // escape state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_PLAIN;
      held_r  <= 8'h00;
    end else if (acc) begin
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
    end
  end

endmodule

`default_nettype wire

/* sv/upd_queue.sv */
// upd_queue: two-entry request queue between classifier and emitter;
// depends on upd_pkg
`default_nettype none

module upd_queue (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire upd_pkg::cmd_t wdata,
  output logic              full,
  input  wire logic         pop,
  output logic              empty,
  output upd_pkg::cmd_t     rdata
);
  import upd_pkg::*;

  localparam int DEPTH = 2;
  localparam int AW    = $clog2(DEPTH);

  cmd_t          mem_r [DEPTH];
  logic [AW-1:0] wptr_r, rptr_r;
  logic [AW:0]   cnt_r;

  assign full  = (cnt_r == (AW+1)'(DEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = mem_r[rptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wptr_r] <= wdata;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) wptr_r <= wptr_r + 1'b1;
      if (pop)  rptr_r <= rptr_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

`default_nettype wire

/* sv/upd_back.sv */
// upd_back: emitter that walks one queued request out a byte per cycle
// while out_ready is high; depends on upd_pkg
`default_nettype none

module upd_back (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         q_empty,
  input  wire upd_pkg::cmd_t q_data,
  output logic              q_pop,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic [7:0]        out_byte,
  output logic              out_last
);
  import upd_pkg::*;

  cmd_t       cur_r;
  logic       busy_r;
  logic [1:0] idx_r;
  logic       final_byte;

  assign final_byte = (idx_r == cur_r.cnt - 2'd1);
  assign out_valid  = busy_r;
  assign out_last   = cur_r.last && final_byte;

  // byte select
  always_comb begin
    case (idx_r)
      2'd0:    out_byte = cur_r.b0;
      2'd1:    out_byte = cur_r.b1;
      default: out_byte = cur_r.b2;
    endcase
  end

  // load the next request when idle or on the final byte of this one
  assign q_pop = !q_empty && (!busy_r || (out_ready && final_byte));

  always_ff @(posedge clk) begin
    if (q_pop) cur_r <= q_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= 2'd0;
    end else if (q_pop) begin
      busy_r <= 1'b1;
      idx_r  <= 2'd0;
    end else if (busy_r && out_ready) begin
      if (final_byte) busy_r <= 1'b0;
      idx_r <= idx_r + 2'd1;
    end
  end

endmodule

`default_nettype wire

/* sv/url_percent_decoder.sv */
// url_percent_decoder: top level, classifier, request queue and emitter;
// depends on upd_pkg, upd_front, upd_queue, upd_back
//
// Decodes URL text one byte per request: '+' becomes a space and '%' with two
// hex digits becomes one byte; a bad escape comes out as '%' and both bytes,
// and a string that ends inside an escape flushes the '%' and any held byte.
// Bytes that map to one result flow at one per cycle while out_ready is high;
// a byte that completes a bad escape yields three results, sent one at a time,
// so input stalls once the two-entry request queue fills. An accepted request
// passes the request queue and the emitter register before its first result.
`default_nettype none

module url_percent_decoder (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_last,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            out_last
);
  import upd_pkg::*;

  cmd_t cmd, q_data;
  logic cmd_push, q_full, q_empty, q_pop, acc;

  assign in_ready = !q_full;
  assign acc      = in_valid && in_ready;

  // classifier
  upd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (acc),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .cmd      (cmd),
    .cmd_push (cmd_push)
  );

  // request queue
  upd_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .wdata (cmd),
    .full  (q_full),
    .pop   (q_pop),
    .empty (q_empty),
    .rdata (q_data)
  );

  // emitter
  upd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

endmodule

`default_nettype wire

/* sim/upd_decode_checker.sv */
// upd_decode_checker: watches the request and result channels of url_percent_decoder,
// predicts the decoded characters and compares them; depends on upd_pkg
`timescale 1ns / 100ps

module upd_decode_checker (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic       in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_last,
  input  wire logic       out_valid,
  input  wire logic       out_ready,
  input  wire logic [7:0] out_byte,
  input  wire logic       out_last,
  output int              mismatches,
  output int              chars_owed
);
  import upd_pkg::*;

  typedef enum logic [1:0] {
    SCAN_TEXT    = 2'd0,
    SCAN_PERCENT = 2'd1,
    SCAN_HOLDING = 2'd2
  } scan_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } out_char_t;

  scan_t      scan;
  logic [7:0] held_ch;
  out_char_t  decoded_q[$];

  // {is a hex digit, digit value}
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    if (c >= "0" && c <= "9") return {1'b1, c[3:0]};
    if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) return {1'b1, c[3:0] + 4'd9};
    return 5'b0;
  endfunction

  function automatic logic [7:0] text_char(input logic [7:0] c);
    return (c == CH_PLUS) ? CH_SPACE : c;
  endfunction

  task automatic owe(input logic [7:0] ch, input logic last);
    out_char_t e;
    e.ch   = ch;
    e.last = last;
    decoded_q = {decoded_q, e};
  endtask

  // advance the escape scanner by one input byte
  task automatic decode_byte(input logic [7:0] b, input logic last);
    logic [4:0] hi;
    logic [4:0] lo;
    case (scan)
      SCAN_PERCENT: begin
        held_ch = b;
        if (last) begin
          scan = SCAN_TEXT;
          owe(CH_PERCENT, 1'b0);
          owe(text_char(b), 1'b1);
        end else begin
          scan = SCAN_HOLDING;
        end
      end
      SCAN_HOLDING: begin
        scan = SCAN_TEXT;
        hi = hex_digit(held_ch);
        lo = hex_digit(b);
        if (hi[4] && lo[4]) begin
          owe({hi[3:0], lo[3:0]}, last);
        end else begin
          owe(CH_PERCENT, 1'b0);
          owe(held_ch, 1'b0);
          owe(b, last);
        end
      end
      default: begin
        scan = SCAN_TEXT;
        if (b == CH_PERCENT) begin
          if (last) owe(CH_PERCENT, 1'b1);
          else scan = SCAN_PERCENT;
        end else begin
          owe(text_char(b), last);
        end
      end
    endcase
  endtask

  // compare each accepted result, then predict from each accepted request
  always @(posedge clk) begin
    out_char_t e;
    if (!rst_n) begin
      scan       = SCAN_TEXT;
      held_ch    = 8'h00;
      mismatches = 0;
      decoded_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (decoded_q.size() == 0) begin
          $error("unexpected result: out_byte %h out_last %b", out_byte, out_last);
          mismatches++;
        end else begin
          e = decoded_q.pop_front();
          if (out_byte !== e.ch) begin
            $error("out_byte: expected %h, actual %h", e.ch, out_byte);
            mismatches++;
          end
          if (out_last !== e.last) begin
            $error("out_last: expected %b, actual %b", e.last, out_last);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) decode_byte(in_byte, in_last);
    end
    chars_owed <= decoded_q.size();
  end

endmodule

/* sim/tb.sv */
// tb: stimulus and verdict for url_percent_decoder; depends on upd_pkg,
// url_percent_decoder and upd_decode_checker
`timescale 1ns / 100ps

module tb;
  import upd_pkg::*;

  localparam int QUIET_LIMIT = 1000;
  localparam int RANDOM_ITEMS = 150;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic [7:0] in_byte = 8'h00;
  logic       in_last = 1'b0;
  logic       out_ready = 1'b0;
  wire logic  in_ready;
  wire logic  out_valid;
  wire logic [7:0] out_byte;
  wire logic  out_last;

  int         mismatches;
  int         chars_owed;
  int         quiet = 0;
  logic       calm = 1'b0;
  logic [7:0] line_q[$];

  always #4 clk = ~clk;

  url_percent_decoder u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_byte (out_byte),
    .out_last (out_last)
  );

  upd_decode_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .out_last  (out_last),
    .mismatches(mismatches),
    .chars_owed(chars_owed)
  );

  // result side stalls at random except in calm stretches
  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(0, 99) >= 8);
  end

  // end the run when nothing moves for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet == QUIET_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  // offer one request, with random gaps in front, and wait for acceptance
  task automatic push_char(input logic [7:0] b, input logic last);
    while (!calm && $urandom_range(0, 99) < 8) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    in_last  <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i], i == s.len() - 1);
  endtask

  function automatic logic [7:0] rand_hex_char();
    int v;
    v = $urandom_range(0, 15);
    if (v < 10) return 8'(8'h30 + v);
    return 8'(($urandom_range(0, 1) ? 8'h61 : 8'h41) + v - 10);
  endfunction

  // one random string: text, plus signs, good and bad escapes, and
  // sometimes an escape cut short by the end of the string
  task automatic build_line();
    int n;
    int r;
    line_q.delete();
    n = $urandom_range(1, 10);
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 35) begin
        line_q = {line_q, 8'($urandom_range(0, 255))};
      end else if (r < 45) begin
        line_q = {line_q, CH_PLUS};
      end else if (r < 70) begin
        line_q = {line_q, CH_PERCENT};
        line_q = {line_q, rand_hex_char()};
        line_q = {line_q, rand_hex_char()};
      end else if (r < 85) begin
        line_q = {line_q, CH_PERCENT};
        line_q = {line_q,
                  $urandom_range(0, 1) ? rand_hex_char() : 8'($urandom_range(0, 255))};
        line_q = {line_q, 8'($urandom_range(0, 255))};
      end else if (r < 93) begin
        line_q = {line_q, CH_PERCENT};
        if ($urandom_range(0, 1)) line_q = {line_q, 8'($urandom_range(0, 255))};
        break;
      end else begin
        line_q = {line_q, $urandom_range(0, 1) ? CH_PERCENT : CH_PLUS};
      end
    end
  endtask

  initial begin
    int sent;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, plus sign, both hex cases, bad pairs, cut escapes
    send_text("+");
    push_char(8'h00, 1'b0);
    push_char(8'hFF, 1'b1);
    send_text("%41%6f");
    send_text("%FF%00");
    send_text("%Fz");
    send_text("%%41");
    send_text("%");
    send_text("%+");
    send_text("%%");

    // random strings, with a calm stretch in the middle
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      build_line();
      calm = (sent >= 70 && sent < 110);
      for (int i = 0; i < line_q.size(); i++) push_char(line_q[i], i == line_q.size() - 1);
      sent += line_q.size();
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    // drain, then wait on for stray results
    @(posedge clk);
    while (chars_owed != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

/* files.f */
sv/upd_pkg.sv
sv/upd_front.sv
sv/upd_queue.sv
sv/upd_back.sv
sv/url_percent_decoder.sv
sim/upd_decode_checker.sv
sim/tb.sv
